// ===== rtl/stxd_pkg.sv =====
// Shared constants for the STX length-prefixed frame deframer with XOR descrambling.
// Holds phase, section and error codes, register indexes and field widths.
// No dependencies.
package stxd_pkg;

    localparam int KEY_BYTES    = 16;
    localparam int KEY_POS_W    = 4;
    localparam int KEY_LEN_W    = 5;
    localparam int MAX_LEN_W    = 21;
    localparam int REMAIN_W     = 21;
    localparam int SHIFT_W      = 24;
    localparam int INDEX_W      = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [7:0] STX_BYTE = 8'h02;

    localparam logic [31:0]        HDR_LEN       = 32'd5;
    localparam logic [INDEX_W-1:0] HDR_END_INDEX = 4'd10;
    localparam logic [INDEX_W-1:0] LEN_LAST_IDX  = 4'd4;
    localparam logic [INDEX_W-1:0] LEN_DONE_IDX  = 4'd5;
    localparam logic [INDEX_W-1:0] FIRST_LEN_IDX = 4'd1;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_HDR  = 2'd2;
    localparam logic [1:0] PH_PAY  = 2'd3;

    localparam logic [1:0] SEC_START   = 2'd0;
    localparam logic [1:0] SEC_LENGTH  = 2'd1;
    localparam logic [1:0] SEC_HEADER  = 2'd2;
    localparam logic [1:0] SEC_PAYLOAD = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
    localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd3;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 21'd35000;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

endpackage

// ===== rtl/stx_length_frame_deframer_xor_unit.sv =====
// Top level of the STX length-prefixed frame deframer with XOR payload descrambling.
// Hunts for the start byte, checks the frame length and descrambles payload bytes.
// Depends on stxd_pkg.
//
// Channel   Direction  Transaction content
// s_*       in         tdata = rx_byte, tuser = action (1 = flush)
// m_*       out        tdata = data_byte, tuser = {error_code, section}, tlast = frame_end
// cfg_*     in         register write: cfg_index selects, cfg_data carries the value
//
// One input is taken per cycle unless the output stalls; a result shows in the next cycle.
// The frame state and the result are computed in a single pass ahead of the output register.
// The output register stalls the input only while it holds a result that is not taken.
// Reset clears the frame state, the output valid and the configuration to default values.
module stx_length_frame_deframer_xor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [3:0]  m_tuser,   // [1:0] section, [3:2] error_code
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [stxd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stxd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [stxd_pkg::MAX_LEN_W-1:0] max_len_reg;
    logic [63:0]                    key_low_reg;
    logic [63:0]                    key_high_reg;
    logic [stxd_pkg::KEY_LEN_W-1:0] key_len_reg;

    logic [1:0]                     phase_reg, phase_next;
    logic [stxd_pkg::REMAIN_W-1:0]  remain_reg, remain_next;
    logic [stxd_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [stxd_pkg::INDEX_W-1:0]   index_reg, index_next;
    logic [stxd_pkg::KEY_POS_W-1:0] key_pos_reg, key_pos_next;

    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;
    logic [1:0] out_sec_reg, out_sec_next;
    logic       out_end_reg, out_end_next;
    logic [1:0] out_err_reg, out_err_next;
    logic       emit;

    logic                            accept;
    logic [31:0]                     frame_len;
    logic                            too_large;
    logic                            too_short;
    logic [stxd_pkg::REMAIN_W-1:0]   remain_dec;
    logic [stxd_pkg::INDEX_W-1:0]    index_inc;
    logic [127:0]                    key_all;
    logic [7:0]                      key_sel;
    logic [stxd_pkg::KEY_LEN_W-1:0]  key_len_eff;
    logic [stxd_pkg::KEY_LEN_W-1:0]  key_pos_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_err_reg, out_sec_reg};
    assign m_tlast  = out_end_reg;

    assign frame_len  = {shift_reg, s_tdata};
    assign too_large  = frame_len > {11'd0, max_len_reg};
    assign too_short  = frame_len <= stxd_pkg::HDR_LEN;
    assign remain_dec = remain_reg - 21'd1;
    assign index_inc  = index_reg + 4'd1;
    assign key_all    = {key_high_reg, key_low_reg};
    assign key_sel    = key_all[{key_pos_reg, 3'b000} +: 8];

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            key_len_eff = 5'd1;
        end
        else if (key_len_reg > 5'(stxd_pkg::KEY_BYTES))
        begin
            key_len_eff = 5'(stxd_pkg::KEY_BYTES);
        end
        else
        begin
            key_len_eff = key_len_reg;
        end
        key_pos_inc = {1'b0, key_pos_reg} + 5'd1;
        if (key_pos_inc >= key_len_eff)
        begin
            key_pos_inc = '0;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        shift_next    = shift_reg;
        index_next    = index_reg;
        key_pos_next  = key_pos_reg;
        emit          = 1'b0;
        out_data_next = s_tdata;
        out_sec_next  = stxd_pkg::SEC_START;
        out_end_next  = 1'b0;
        out_err_next  = stxd_pkg::ERR_NONE;
        if (s_tuser == stxd_pkg::ACT_FLUSH)
        begin
            phase_next = stxd_pkg::PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                stxd_pkg::PH_HUNT:
                begin
                    if (s_tdata == stxd_pkg::STX_BYTE)
                    begin
                        phase_next = stxd_pkg::PH_LEN;
                        shift_next = '0;
                        index_next = stxd_pkg::FIRST_LEN_IDX;
                        emit       = 1'b1;
                    end
                end
                stxd_pkg::PH_LEN:
                begin
                    emit         = 1'b1;
                    out_sec_next = stxd_pkg::SEC_LENGTH;
                    if (index_reg < stxd_pkg::LEN_LAST_IDX)
                    begin
                        shift_next = {shift_reg[15:0], s_tdata};
                        index_next = index_inc;
                    end
                    else
                    begin
                        index_next = stxd_pkg::LEN_DONE_IDX;
                        if (too_large)
                        begin
                            phase_next   = stxd_pkg::PH_HUNT;
                            out_end_next = 1'b1;
                            out_err_next = stxd_pkg::ERR_TOO_LARGE;
                        end
                        else if (too_short)
                        begin
                            phase_next   = stxd_pkg::PH_HUNT;
                            out_end_next = 1'b1;
                            out_err_next = stxd_pkg::ERR_TOO_SHORT;
                        end
                        else
                        begin
                            remain_next = stxd_pkg::REMAIN_W'(frame_len - stxd_pkg::HDR_LEN);
                            phase_next  = stxd_pkg::PH_HDR;
                        end
                    end
                end
                stxd_pkg::PH_HDR:
                begin
                    emit         = 1'b1;
                    out_sec_next = stxd_pkg::SEC_HEADER;
                    remain_next  = remain_dec;
                    index_next   = index_inc;
                    if (index_inc >= stxd_pkg::HDR_END_INDEX)
                    begin
                        key_pos_next = '0;
                        if (remain_dec == '0)
                        begin
                            phase_next   = stxd_pkg::PH_HUNT;
                            out_end_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = stxd_pkg::PH_PAY;
                        end
                    end
                    else if (remain_dec == '0)
                    begin
                        phase_next   = stxd_pkg::PH_HUNT;
                        out_end_next = 1'b1;
                        out_err_next = stxd_pkg::ERR_TOO_SHORT;
                    end
                end
                stxd_pkg::PH_PAY:
                begin
                    emit          = 1'b1;
                    out_sec_next  = stxd_pkg::SEC_PAYLOAD;
                    out_data_next = s_tdata ^ key_sel;
                    key_pos_next  = key_pos_inc[stxd_pkg::KEY_POS_W-1:0];
                    remain_next   = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next   = stxd_pkg::PH_HUNT;
                        out_end_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = stxd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= stxd_pkg::MAX_LEN_RESET;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= stxd_pkg::KEY_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                stxd_pkg::REG_MAX_LEN:  max_len_reg  <= cfg_data[stxd_pkg::MAX_LEN_W-1:0];
                stxd_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                stxd_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                stxd_pkg::REG_KEY_LEN:  key_len_reg  <= cfg_data[stxd_pkg::KEY_LEN_W-1:0];
                default:                key_len_reg  <= key_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= stxd_pkg::PH_HUNT;
            remain_reg  <= '0;
            shift_reg   <= '0;
            index_reg   <= '0;
            key_pos_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            shift_reg   <= shift_next;
            index_reg   <= index_next;
            key_pos_reg <= key_pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
            out_sec_reg  <= out_sec_next;
            out_end_reg  <= out_end_next;
            out_err_reg  <= out_err_next;
        end
    end

`ifndef SYNTH
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == stxd_pkg::PH_PAY |-> index_reg == stxd_pkg::HDR_END_INDEX)
        else $error("Payload phase entered before the header was complete.");

    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == stxd_pkg::PH_HDR || phase_reg == stxd_pkg::PH_PAY)
            |-> remain_reg != '0)
        else $error("Frame still open with no bytes remaining.");

    a_error_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg != stxd_pkg::ERR_NONE |-> out_end_reg)
        else $error("Error reported on a byte that does not end the frame.");

    a_large_on_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg == stxd_pkg::ERR_TOO_LARGE
            |-> out_sec_reg == stxd_pkg::SEC_LENGTH)
        else $error("Length too large reported outside the length field.");

    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && out_end_next |=> phase_reg == stxd_pkg::PH_HUNT)
        else $error("Frame ended without returning to the start hunt.");
`endif

endmodule

// ===== bench/tb_stx_length_frame_deframer_xor_unit.sv =====
// Self-checking testbench for the STX length-prefixed frame deframer with XOR descrambling.
// Drives framed byte streams and register settings, and predicts every output transaction.
// Depends on stxd_pkg and stx_length_frame_deframer_xor_unit.
module tb_stx_length_frame_deframer_xor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] section;
        logic       frame_end;
        logic [1:0] error_code;
    } frame_byte_t;

    class deframe_scoreboard;
        frame_byte_t                    expected_bytes[$];
        int                             errors;
        logic [stxd_pkg::MAX_LEN_W-1:0] max_len;
        logic [127:0]                   key;
        logic [stxd_pkg::KEY_LEN_W-1:0] key_len;
        logic [1:0]                     ph;
        logic [stxd_pkg::REMAIN_W-1:0]  remain;
        logic [stxd_pkg::SHIFT_W-1:0]   len_shift;
        logic [stxd_pkg::INDEX_W-1:0]   byte_idx;
        logic [stxd_pkg::KEY_POS_W-1:0] key_pos;

        function new();
            errors = 0;
            max_len = stxd_pkg::MAX_LEN_RESET;
            key = '0;
            key_len = stxd_pkg::KEY_LEN_RESET;
            ph = stxd_pkg::PH_HUNT;
            remain = '0;
            len_shift = '0;
            byte_idx = '0;
            key_pos = '0;
        endfunction

        function void write_reg(logic [stxd_pkg::CFG_INDEX_W-1:0] idx,
                                logic [stxd_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                stxd_pkg::REG_MAX_LEN:  max_len = value[stxd_pkg::MAX_LEN_W-1:0];
                stxd_pkg::REG_KEY_LOW:  key[63:0] = value;
                stxd_pkg::REG_KEY_HIGH: key[127:64] = value;
                stxd_pkg::REG_KEY_LEN:  key_len = value[stxd_pkg::KEY_LEN_W-1:0];
                default:                ;
            endcase
        endfunction

        function void push(logic [7:0] d, logic [1:0] sec, logic last, logic [1:0] err);
            expected_bytes.push_back({d, sec, last, err});
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_input(logic act, logic [7:0] b);
            logic [31:0] flen;
            logic [7:0]  kb;
            int          klen;
            int          nk;
            if (act == stxd_pkg::ACT_FLUSH)
            begin
                ph = stxd_pkg::PH_HUNT;
                return;
            end
            case (ph)
                stxd_pkg::PH_HUNT:
                begin
                    if (b == stxd_pkg::STX_BYTE)
                    begin
                        ph = stxd_pkg::PH_LEN;
                        len_shift = '0;
                        byte_idx = stxd_pkg::FIRST_LEN_IDX;
                        push(b, stxd_pkg::SEC_START, 1'b0, stxd_pkg::ERR_NONE);
                    end
                end
                stxd_pkg::PH_LEN:
                begin
                    if (byte_idx < stxd_pkg::LEN_LAST_IDX)
                    begin
                        len_shift = {len_shift[15:0], b};
                        byte_idx = byte_idx + stxd_pkg::INDEX_W'(1);
                        push(b, stxd_pkg::SEC_LENGTH, 1'b0, stxd_pkg::ERR_NONE);
                    end
                    else
                    begin
                        flen = {len_shift, b};
                        byte_idx = stxd_pkg::LEN_DONE_IDX;
                        if (flen > 32'(max_len))
                        begin
                            ph = stxd_pkg::PH_HUNT;
                            push(b, stxd_pkg::SEC_LENGTH, 1'b1, stxd_pkg::ERR_TOO_LARGE);
                        end
                        else if (flen <= stxd_pkg::HDR_LEN)
                        begin
                            ph = stxd_pkg::PH_HUNT;
                            push(b, stxd_pkg::SEC_LENGTH, 1'b1, stxd_pkg::ERR_TOO_SHORT);
                        end
                        else
                        begin
                            remain = stxd_pkg::REMAIN_W'(flen - stxd_pkg::HDR_LEN);
                            ph = stxd_pkg::PH_HDR;
                            push(b, stxd_pkg::SEC_LENGTH, 1'b0, stxd_pkg::ERR_NONE);
                        end
                    end
                end
                stxd_pkg::PH_HDR:
                begin
                    remain = remain - stxd_pkg::REMAIN_W'(1);
                    byte_idx = byte_idx + stxd_pkg::INDEX_W'(1);
                    if (byte_idx >= stxd_pkg::HDR_END_INDEX)
                    begin
                        key_pos = '0;
                        if (remain == 0)
                        begin
                            ph = stxd_pkg::PH_HUNT;
                            push(b, stxd_pkg::SEC_HEADER, 1'b1, stxd_pkg::ERR_NONE);
                        end
                        else
                        begin
                            ph = stxd_pkg::PH_PAY;
                            push(b, stxd_pkg::SEC_HEADER, 1'b0, stxd_pkg::ERR_NONE);
                        end
                    end
                    else if (remain == 0)
                    begin
                        ph = stxd_pkg::PH_HUNT;
                        push(b, stxd_pkg::SEC_HEADER, 1'b1, stxd_pkg::ERR_TOO_SHORT);
                    end
                    else
                    begin
                        push(b, stxd_pkg::SEC_HEADER, 1'b0, stxd_pkg::ERR_NONE);
                    end
                end
                default:
                begin
                    kb = key[int'(key_pos) * 8 +: 8];
                    klen = int'(key_len);
                    if (klen == 0)
                        klen = 1;
                    if (klen > stxd_pkg::KEY_BYTES)
                        klen = stxd_pkg::KEY_BYTES;
                    nk = int'(key_pos) + 1;
                    if (nk >= klen)
                        nk = 0;
                    key_pos = stxd_pkg::KEY_POS_W'(nk);
                    remain = remain - stxd_pkg::REMAIN_W'(1);
                    if (remain == 0)
                        ph = stxd_pkg::PH_HUNT;
                    push(b ^ kb, stxd_pkg::SEC_PAYLOAD, remain == 0, stxd_pkg::ERR_NONE);
                end
            endcase
        endfunction

        function void check_output(logic [7:0] data, logic [3:0] tuser, logic tlast);
            frame_byte_t got;
            frame_byte_t want;
            got = {data, tuser[1:0], tlast, tuser[3:2]};
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: expected no output, actual data %h section %0d end %0b error %0d",
                         $time, got.data, got.section, got.frame_end, got.error_code);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.section !== want.section ||
                got.frame_end !== want.frame_end || got.error_code !== want.error_code)
            begin
                errors++;
                $display("%0t: mismatch expected data %h section %0d end %0b error %0d,",
                         $time, want.data, want.section, want.frame_end, want.error_code);
                $display("%0t:          actual data %h section %0d end %0b error %0d",
                         $time, got.data, got.section, got.frame_end, got.error_code);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [7:0]                       m_tdata;
    logic [3:0]                       m_tuser;
    logic                             m_tlast;
    logic                             cfg_wr_en;
    logic [stxd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [stxd_pkg::CFG_DATA_W-1:0]  cfg_data;

    deframe_scoreboard                sb;
    int                               send_idle_pct;
    int                               recv_stall_pct;
    bit                               hold_req;
    logic [stxd_pkg::MAX_LEN_W-1:0]   cur_max;
    int                               frame_items;

    stx_length_frame_deframer_xor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_output(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
        end
    end

    // The receiver also serves a long hold-off on request so that the input backs up.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [31:0] flen, input int nbody);
        send_item(stxd_pkg::ACT_BYTE, stxd_pkg::STX_BYTE);
        send_item(stxd_pkg::ACT_BYTE, flen[31:24]);
        send_item(stxd_pkg::ACT_BYTE, flen[23:16]);
        send_item(stxd_pkg::ACT_BYTE, flen[15:8]);
        send_item(stxd_pkg::ACT_BYTE, flen[7:0]);
        repeat (nbody)
            send_item(stxd_pkg::ACT_BYTE, 8'($urandom));
        frame_items += 5 + nbody;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [stxd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [stxd_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic setup_phase(input int p);
        logic [stxd_pkg::MAX_LEN_W-1:0] max_v;
        logic [stxd_pkg::KEY_LEN_W-1:0] klen_v;
        case (p)
            0:
            begin
                max_v = 21'd35000;
                klen_v = 5'd16;
            end
            1:
            begin
                max_v = 21'd10;
                klen_v = 5'd1;
            end
            2:
            begin
                max_v = 21'd1048576;
                klen_v = 5'd0;
            end
            3:
            begin
                max_v = 21'd7;
                klen_v = 5'd17;
            end
            4:
            begin
                max_v = 21'h1FFFFF;
                klen_v = 5'd31;
            end
            5:
            begin
                max_v = 21'd60;
                klen_v = 5'($urandom_range(2, 15));
            end
            6:
            begin
                max_v = 21'($urandom_range(10, 400));
                klen_v = 5'($urandom_range(1, 16));
            end
            default:
            begin
                max_v = 21'd400;
                klen_v = 5'd3;
            end
        endcase
        write_cfg(stxd_pkg::REG_MAX_LEN, 64'(max_v));
        write_cfg(stxd_pkg::REG_KEY_LOW, {$urandom, $urandom});
        write_cfg(stxd_pkg::REG_KEY_HIGH, {$urandom, $urandom});
        write_cfg(stxd_pkg::REG_KEY_LEN, 64'(klen_v));
        cfg_wr_en <= 1'b0;
        cur_max = max_v;
    endtask

    // Lengths that pass the checks stay at 400 or below so that frames remain short.
    function automatic logic [31:0] pick_length();
        int r;
        int lim;
        r = $urandom_range(0, 99);
        lim = (cur_max < 400) ? int'(cur_max) : 400;
        if (r < 6)
            return $urandom_range(0, 9);
        if (r < 12)
            return 32'd10;
        if (r < 16 && cur_max <= 400)
            return 32'(cur_max);
        if (r < 22)
            return 32'(cur_max) + 1;
        if (r < 30)
            return {8'($urandom_range(1, 255)), 24'($urandom)};
        if (lim < 11)
            return $urandom_range(0, 20);
        if (r < 33)
            return $urandom_range(11, lim);
        return $urandom_range(11, (lim < 48) ? lim : 48);
    endfunction

    task automatic random_frame();
        logic [31:0] flen;
        int          nbody;
        if ($urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 3))
                send_item(stxd_pkg::ACT_BYTE, 8'($urandom));
        if ($urandom_range(0, 99) < 4)
            send_item(stxd_pkg::ACT_FLUSH, 8'($urandom));
        flen = pick_length();
        if (flen > 32'(cur_max) || flen <= stxd_pkg::HDR_LEN)
            nbody = 0;
        else
            nbody = int'(flen) - 5;
        if ($urandom_range(0, 99) < 8)
        begin
            nbody = $urandom_range(0, nbody + 3);
            send_frame(flen, nbody);
            if ($urandom_range(0, 1) == 1)
                send_item(stxd_pkg::ACT_FLUSH, 8'($urandom));
        end
        else
        begin
            send_frame(flen, nbody);
        end
    endtask

    initial
    begin
        int p;
        int target;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        cur_max = stxd_pkg::MAX_LEN_RESET;
        frame_items = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(stxd_pkg::ACT_BYTE, 8'hFF);
        send_item(stxd_pkg::ACT_FLUSH, 8'hFF);
        send_frame(32'hFFFF_FFFF, 0);
        send_frame(32'd5, 0);
        send_frame(32'd6, 1);
        send_item(stxd_pkg::ACT_BYTE, stxd_pkg::STX_BYTE);
        send_item(stxd_pkg::ACT_FLUSH, 8'h00);

        for (p = 0; p < 8; p++)
        begin
            settle();
            setup_phase(p);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            if (p == 0)
                hold_req = 1'b1;
            target = frame_items + 200;
            while (frame_items < target)
                random_frame();
        end
        settle();
        repeat (10)
            @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
